@@ sv/tksi_pkg.sv @@
// Shared types and constants for the top-k sorted insertion list.
// Used by tksi_cell and top_k_sorted_insert_top; no dependencies.
`timescale 1ns / 1ps

package tksi_pkg;

  localparam int SCORE_W       = 16;
  localparam int TAG_W         = 32;
  localparam int SLOT_W        = 5;
  localparam int SLOTS_DEFAULT = 20;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic               ins_en;
    logic               rd_en;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [SLOT_W-1:0]  read_index;
    logic [SCORE_W-1:0] empty_score;
  } cell_cmd_t;

  // Per-cell result contribution, zero unless the cell placed or was read
  typedef struct packed {
    logic               place;
    logic [SLOT_W-1:0]  slot;
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } cell_res_t;

endpackage

@@ sv/tksi_cell.sv @@
// One slot of the sorted list: compare against the new score, keep,
// load the new item, or take the neighbor's entry. Depends on tksi_pkg.
`timescale 1ns / 1ps

module tksi_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tksi_pkg::cell_cmd_t cmd,
  input  tksi_pkg::entry_t   prev_entry,
  input  logic               prev_found,
  output tksi_pkg::entry_t   entry,
  output logic               found,
  output tksi_pkg::cell_res_t res
);
  import tksi_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_ID   = SLOT_W'(IDX);
  localparam bit                REACHABLE = (IDX < (1 << SLOT_W));

  entry_t             entry_r, entry_nxt;
  logic [SCORE_W-1:0] cmp_score;
  logic               lt;
  logic               place;
  logic               hit;

  assign cmp_score = entry_r.valid ? entry_r.score : cmd.empty_score;
  assign lt        = cmp_score < cmd.score;
  assign found     = prev_found | lt;
  assign place     = cmd.ins_en & lt & ~prev_found;
  assign hit       = cmd.rd_en & REACHABLE & (cmd.read_index == SLOT_ID);
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en) begin
      // an earlier slot took the item: everything from there shifts down
      if (prev_found) begin
        entry_nxt = prev_entry;
      end else if (lt) begin
        entry_nxt.valid = 1'b1;
        entry_nxt.score = cmd.score;
        entry_nxt.tag   = cmd.tag;
      end
    end
  end

  always_comb begin
    res.place = place;
    res.slot  = place ? SLOT_ID : '0;
    res.valid = hit & entry_r.valid;
    res.score = hit ? entry_r.score : '0;
    res.tag   = hit ? entry_r.tag : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

@@ sv/top_k_sorted_insert_top.sv @@
// Top level of the top-k sorted insertion list: a chain of tksi_cell slots
// plus the result register. Depends on tksi_pkg and tksi_cell.
`timescale 1ns / 1ps

// Keeps the SLOTS best records in descending score order. busy never rises,
// so a new command (insert or read) may be issued at every clock edge, and
// its result appears with out_strobe on the cycle after start, for exactly
// one cycle; the receiver cannot stall it. The insert compare and shift
// happens in the same cycle across the whole cell chain, so a read issued
// right after an insert sees the new contents. empty_score is written
// through cfg_* and is always ready.
module top_k_sorted_insert_top #(
  parameter int SLOTS = tksi_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [tksi_pkg::SCORE_W-1:0] in_score,
  input  logic [tksi_pkg::TAG_W-1:0]   in_tag,
  input  logic [tksi_pkg::SLOT_W-1:0]  in_read_index,
  output logic                         out_strobe,
  output logic                         out_accepted,
  output logic [tksi_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_slot_valid,
  output logic [tksi_pkg::SCORE_W-1:0] out_slot_score,
  output logic [tksi_pkg::TAG_W-1:0]   out_slot_tag,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tksi_pkg::SCORE_W-1:0] cfg_empty_score
);
  import tksi_pkg::*;

  logic [SCORE_W-1:0] empty_score_r;
  cell_cmd_t          cmd;
  entry_t             entries [SLOTS];
  logic               founds  [SLOTS];
  cell_res_t          results [SLOTS];
  cell_res_t          merged;

  logic               strobe_r;
  logic               accepted_r, accepted_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               slot_valid_r;
  logic [SCORE_W-1:0] slot_score_r;
  logic [TAG_W-1:0]   slot_tag_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    cmd.ins_en      = start & (in_command == CMD_INSERT);
    cmd.rd_en       = start & (in_command == CMD_READ);
    cmd.score       = in_score;
    cmd.tag         = in_tag;
    cmd.read_index  = in_read_index;
    cmd.empty_score = empty_score_r;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tksi_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prev_entry ('0),
        .prev_found (1'b0),
        .entry      (entries[i]),
        .found      (founds[i]),
        .res        (results[i])
      );
    end else begin : g_body
      tksi_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prev_entry (entries[i-1]),
        .prev_found (founds[i-1]),
        .entry      (entries[i]),
        .found      (founds[i]),
        .res        (results[i])
      );
    end
  end

  // at most one cell places and at most one cell is read
  always_comb begin
    merged = '0;
    for (int i = 0; i < SLOTS; i++) begin
      merged = merged | results[i];
    end
  end

  always_comb begin
    accepted_nxt = 1'b0;
    slot_nxt     = in_read_index;
    if (in_command == CMD_INSERT) begin
      accepted_nxt = merged.place;
      slot_nxt     = merged.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_score_r <= '0;
      strobe_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        empty_score_r <= cfg_empty_score;
      end
      strobe_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      accepted_r   <= accepted_nxt;
      slot_r       <= slot_nxt;
      slot_valid_r <= merged.valid;
      slot_score_r <= merged.score;
      slot_tag_r   <= merged.tag;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_accepted   = accepted_r;
  assign out_slot       = slot_r;
  assign out_slot_valid = slot_valid_r;
  assign out_slot_score = slot_score_r;
  assign out_slot_tag   = slot_tag_r;

endmodule

@@ bench/top_k_sorted_insert_top_test.sv @@
// Testbench for top_k_sorted_insert_top: drives inserts, slot reads and
// empty-score writes, predicts each result and compares it field by field.
// Depends on tksi_pkg and the top_k_sorted_insert_top RTL.
`timescale 1ns / 1ps

module top_k_sorted_insert_top_test;
  import tksi_pkg::*;

  localparam int SLOTS       = SLOTS_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 305;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    logic               slot_valid;
    logic [SCORE_W-1:0] slot_score;
    logic [TAG_W-1:0]   slot_tag;
  } outcome_t;

  // Mirror of the ranking list; predicts the outcome of every accepted item
  class ranking_board;
    logic [SCORE_W-1:0] empty_cmp;
    logic [SCORE_W-1:0] entry_score [SLOTS];
    logic [TAG_W-1:0]   entry_tag   [SLOTS];
    logic               entry_valid [SLOTS];
    outcome_t           pending_outcomes [$];
    int n_errors, n_placed, n_rejected, n_reads;

    function new();
      empty_cmp = '0;
      for (int k = 0; k < SLOTS; k++) begin
        entry_score[k] = '0;
        entry_tag[k]   = '0;
        entry_valid[k] = 1'b0;
      end
    endfunction

    function void set_empty(logic [SCORE_W-1:0] v);
      empty_cmp = v;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void take_command(logic cmd, logic [SCORE_W-1:0] sc, logic [TAG_W-1:0] tg,
                               logic [SLOT_W-1:0] idx);
      outcome_t           o;
      int                 pos;
      int                 k;
      logic [SCORE_W-1:0] cmp;
      o = '0;
      if (cmd == CMD_INSERT) begin
        pos = SLOTS;
        for (k = 0; k < SLOTS; k++) begin
          cmp = entry_valid[k] ? entry_score[k] : empty_cmp;
          // strict compare: a tie lands behind the earlier entry
          if (pos == SLOTS && cmp < sc) pos = k;
        end
        if (pos < SLOTS) begin
          for (k = SLOTS - 1; k > pos; k--) begin
            entry_score[k] = entry_score[k-1];
            entry_tag[k]   = entry_tag[k-1];
            entry_valid[k] = entry_valid[k-1];
          end
          entry_score[pos] = sc;
          entry_tag[pos]   = tg;
          entry_valid[pos] = 1'b1;
          o.accepted = 1'b1;
          o.slot     = SLOT_W'(pos);
          n_placed++;
        end else begin
          n_rejected++;
        end
      end else begin
        o.slot = idx;
        if (idx < SLOTS) begin
          o.slot_valid = entry_valid[idx];
          o.slot_score = entry_score[idx];
          o.slot_tag   = entry_tag[idx];
        end
        n_reads++;
      end
      pending_outcomes.push_back(o);
    endfunction

    function void match_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no item outstanding: slot %0d", got.slot);
        n_errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        n_errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        n_errors++;
      end
      if (got.slot_valid !== want.slot_valid) begin
        $error("slot_valid: expected %0d, got %0d", want.slot_valid, got.slot_valid);
        n_errors++;
      end
      if (got.slot_score !== want.slot_score) begin
        $error("slot_score: expected %0d, got %0d", want.slot_score, got.slot_score);
        n_errors++;
      end
      if (got.slot_tag !== want.slot_tag) begin
        $error("slot_tag: expected %h, got %h", want.slot_tag, got.slot_tag);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic               in_command      = CMD_INSERT;
  logic [SCORE_W-1:0] in_score        = '0;
  logic [TAG_W-1:0]   in_tag          = '0;
  logic [SLOT_W-1:0]  in_read_index   = '0;
  logic               out_strobe;
  logic               out_accepted;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_slot_valid;
  logic [SCORE_W-1:0] out_slot_score;
  logic [TAG_W-1:0]   out_slot_tag;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic [SCORE_W-1:0] cfg_empty_score = '0;

  ranking_board board;
  int           n_settings;
  int           quiet_cycles;

  always #6 clk = ~clk;

  top_k_sorted_insert_top #(.SLOTS(SLOTS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_score       (in_score),
    .in_tag         (in_tag),
    .in_read_index  (in_read_index),
    .out_strobe     (out_strobe),
    .out_accepted   (out_accepted),
    .out_slot       (out_slot),
    .out_slot_valid (out_slot_valid),
    .out_slot_score (out_slot_score),
    .out_slot_tag   (out_slot_tag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_empty_score(cfg_empty_score)
  );

  // Sample at the rising edge, before the block's own updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1)
        board.match_result({out_accepted, out_slot, out_slot_valid, out_slot_score,
                            out_slot_tag});
      if (start && busy === 1'b0)
        board.take_command(in_command, in_score, in_tag, in_read_index);
      if (cfg_valid && cfg_ready === 1'b1)
        board.set_empty(cfg_empty_score);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_strobe === 1'b1 || (start && busy === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic issue(input logic cmd, input logic [SCORE_W-1:0] sc,
                       input logic [TAG_W-1:0] tg, input logic [SLOT_W-1:0] idx);
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= cmd;
    in_score      <= sc;
    in_tag        <= tg;
    in_read_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic insert_rec(input logic [SCORE_W-1:0] sc, input logic [TAG_W-1:0] tg);
    issue(CMD_INSERT, sc, tg, SLOT_W'($urandom));
  endtask

  task automatic read_slot(input logic [SLOT_W-1:0] idx);
    issue(CMD_READ, SCORE_W'($urandom), $urandom, idx);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_empty(input logic [SCORE_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_empty_score <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Scores biased toward ties, the tail of the list and the empty score
  function automatic logic [SCORE_W-1:0] choose_score();
    int r, v, d;
    r = $urandom_range(0, 99);
    d = $urandom_range(0, 6);
    if (r < 35)      v = $urandom_range(0, 65535);
    else if (r < 55) v = int'(board.entry_score[$urandom_range(0, SLOTS - 1)]);
    else if (r < 75) v = int'(board.entry_score[SLOTS-1]) + d - 3;
    else if (r < 85) v = int'(board.empty_cmp) + (d % 3) - 1;
    else if (r < 95) v = (d < 3) ? 0 : 65535;
    else             v = $urandom_range(0, 15);
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return SCORE_W'(v);
  endfunction

  function automatic int choose_gap(input int i);
    int r;
    r = $urandom_range(0, 99);
    if (i % 200 < 50) return 0;   // back-to-back stretch
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 99) < 85) read_slot(SLOT_W'($urandom_range(0, SLOTS - 1)));
      else read_slot(SLOT_W'($urandom_range(SLOTS, 31)));
    end else begin
      insert_rec(choose_score(), $urandom);
    end
  endtask

  initial begin
    logic [SCORE_W-1:0] settings [6];
    board        = new();
    n_settings   = 0;
    quiet_cycles = 0;
    settings = '{16'h0000, 16'hFFFF, 16'd1000, 16'h8000, SCORE_W'($urandom), 16'h0001};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, out-of-range reads, ties, extremes
    read_slot('0);
    read_slot(SLOT_W'(SLOTS - 1));
    read_slot(SLOT_W'(SLOTS));
    read_slot(5'd31);
    insert_rec(16'd0, 32'hFFFF_FFFF);      // ties the empty score: rejected
    insert_rec(16'd100, 32'h0000_0001);
    insert_rec(16'd100, 32'h0000_0002);    // tie goes behind
    insert_rec(16'hFFFF, 32'hFFFF_FFFF);
    insert_rec(16'd50, 32'h0000_0000);
    insert_rec(16'd1, 32'hA5A5_A5A5);
    for (int k = 0; k < 6; k++) read_slot(SLOT_W'(k));
    read_slot(SLOT_W'(SLOTS - 1));

    foreach (settings[p]) begin
      write_empty(settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        pause(choose_gap(i));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d placements, %0d rejected inserts and %0d slot reads",
             board.n_placed, board.n_rejected, board.n_reads);
    $display("Used %0d empty-slot score settings, both extremes among them", n_settings);
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", board.n_errors, board.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
